// File: src/user_priority_up_down_table_defines.svh
// assertion macros for the user priority table checker
`ifndef USER_PRIORITY_UP_DOWN_TABLE_DEFINES_SVH
`define USER_PRIORITY_UP_DOWN_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define UPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define UPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/upd_pkg.sv
// shared types and codes of the user priority table
`default_nettype none
package upd_pkg;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_REPORT = 3'd1,
    MODE_GETP   = 3'd2,
    MODE_SETP   = 3'd3,
    MODE_TICK   = 3'd4,
    MODE_SLOT   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    JS_RUNNING = 2'd0,
    JS_PENDING = 2'd1
  } job_status_e;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2
  } res_status_e;

  typedef enum logic {
    CFG_STEP  = 1'b0,
    CFG_HEAVY = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_CLEAR,
    OP_INC,
    OP_SETP,
    OP_TICK
  } alu_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_MISS,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [31:0] prio;
    logic [15:0] pending;
    logic [15:0] running;
    logic [15:0] key;
  } entry_t;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

endpackage
`default_nettype wire

// File: src/upd_mem.sv
// single-port-write, registered-read entry memory
`default_nettype none
module upd_mem
  import upd_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output entry_t             rdata_o
);

  entry_t mem [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: src/upd_alu.sv
// shared entry update unit: count clear and increments, priority write and up-down tick
`default_nettype none
module upd_alu
  import upd_pkg::*;
(
  input  wire entry_t             ent_i,
  input  wire alu_op_e            op_i,
  input  wire logic        [1:0]  job_status_i,
  input  wire logic        [15:0] step_i,
  input  wire logic signed [31:0] heavy_i,
  input  wire logic signed [31:0] new_prio_i,
  output entry_t                  ent_o
);

  logic        [31:0] prod;
  logic signed [33:0] p;
  logic signed [33:0] st;
  logic signed [33:0] hv;
  logic signed [33:0] r;
  logic        [31:0] sat;

  assign prod = 32'(ent_i.running) * 32'(step_i);
  assign p    = {{2{ent_i.prio[31]}}, ent_i.prio};
  assign st   = {18'd0, step_i};
  assign hv   = {{2{heavy_i[31]}}, heavy_i};

  always_comb begin
    r = '0;
    if (ent_i.running != '0) begin
      r = p + $signed({2'b00, prod});
    end else if (ent_i.pending != '0) begin
      r = p - st;
    end else if (p > 34'sd0) begin
      r = (p > hv) ? hv : (p - st);
      if (r < 34'sd0) begin
        r = '0;
      end
    end else if (p < 34'sd0) begin
      r = p + st;
      if (r > 34'sd0) begin
        r = '0;
      end
    end
  end

  // saturate to the 32-bit signed range
  always_comb begin
    if ((r[33:31] == 3'b000) || (r[33:31] == 3'b111)) begin
      sat = r[31:0];
    end else if (r[33]) begin
      sat = 32'h8000_0000;
    end else begin
      sat = 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    ent_o = ent_i;
    unique case (op_i)
      OP_CLEAR: begin
        ent_o.running = '0;
        ent_o.pending = '0;
      end
      OP_INC: begin
        if (job_status_i == JS_RUNNING) begin
          if (ent_i.running != CNT_MAX) ent_o.running = ent_i.running + 16'd1;
        end else if (job_status_i == JS_PENDING) begin
          if (ent_i.pending != CNT_MAX) ent_o.pending = ent_i.pending + 16'd1;
        end
      end
      OP_SETP: ent_o.prio = new_prio_i;
      OP_TICK: ent_o.prio = sat;
      OP_PASS: ent_o = ent_i;
      default: ent_o = ent_i;
    endcase
  end

endmodule
`default_nettype wire

// File: src/user_priority_up_down_table.sv
// top level: sequencer, registers and channels of the user priority table
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/s_axis_tready tuser mode, tdata command fields
//  m_axis    out  m_axis_tvalid/m_axis_tready tuser status, tdata entry fields
//  cfg       in   cfg_valid_i/cfg_ready_o     cfg_index_i, cfg_data_i
//
//  clear and tick read and write back each table entry in turn; a key lookup
//  reads entries until the key matches, with a miss state if none does;
//  a slot read reads one entry if in range; other modes read no entry.
//  entries are read over the one memory read port, which has registered data.
//  rst_ni clears the user count and control; entry memory needs no clearing.
//  a beat is taken only in idle; a result held by a stalled m_axis does not
//  stop the next beat, only the following result waits for the output.
`default_nettype none
module user_priority_up_down_table
  import upd_pkg::*;
#(
  parameter int unsigned MAX_USERS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // user_key, job_status, new_priority, slot_index
  input  wire logic [55:0] s_axis_tdata,
  // mode
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // priority_out, key_out, running_out, pending_out, active_users_out
  output logic [87:0]      m_axis_tdata,
  // result_status
  output logic [1:0]       m_axis_tuser,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int unsigned CW = $clog2(MAX_USERS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_USERS);

  state_e             state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [CW-1:0]      active_q, active_d;
  logic [2:0]         mode_q;
  logic [15:0]        key_q;
  logic [1:0]         js_q;
  logic [31:0]        np_q;
  logic [15:0]        step_q;
  logic signed [31:0] heavy_q;
  logic [1:0]         res_status_q, res_status_d;
  entry_t             res_entry_q, res_entry_d;
  logic               res_we;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_status_q;
  entry_t             out_entry_q;
  logic [5:0]         out_active_q;

  logic               in_acc, out_free, out_load;
  logic [2:0]         in_mode;
  logic [4:0]         in_slot;
  logic               in_lookup, in_sweep, q_lookup, q_sweep;
  logic               tbl_empty, tbl_full, last, found, slot_ok;
  logic [CW:0]        idx_nxt;
  logic [CW+4:0]      slot_ext;
  logic [CW+5:0]      act_ext;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata, mem_rdata, fresh, alu_in, alu_out;
  alu_op_e            alu_op;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_mode  = s_axis_tuser;
  assign in_slot  = s_axis_tdata[54:50];
  assign out_free = !out_valid_q || m_axis_tready;

  assign in_lookup = (in_mode == MODE_REPORT) || (in_mode == MODE_GETP) ||
                     (in_mode == MODE_SETP);
  assign in_sweep  = (in_mode == MODE_CLEAR) || (in_mode == MODE_TICK);
  assign q_lookup  = (mode_q == MODE_REPORT) || (mode_q == MODE_GETP) ||
                     (mode_q == MODE_SETP);
  assign q_sweep   = (mode_q == MODE_CLEAR) || (mode_q == MODE_TICK);

  assign tbl_empty = (active_q == '0);
  assign tbl_full  = (active_q >= MAX_CNT);
  assign idx_nxt   = {{(CW + 1 - AW){1'b0}}, idx_q} + {{CW{1'b0}}, 1'b1};
  assign last      = (idx_nxt == {1'b0, active_q});
  assign found     = (mem_rdata.key == key_q);
  assign slot_ext  = {{CW{1'b0}}, in_slot};
  assign slot_ok   = (slot_ext < {5'd0, active_q});
  assign act_ext   = {6'd0, active_q};

  always_comb begin
    fresh     = '0;
    fresh.key = key_q;
  end

  assign alu_in = (state_q == S_MISS) ? fresh : mem_rdata;

  always_comb begin
    unique case (mode_q)
      MODE_CLEAR:  alu_op = OP_CLEAR;
      MODE_REPORT: alu_op = OP_INC;
      MODE_SETP:   alu_op = OP_SETP;
      MODE_TICK:   alu_op = OP_TICK;
      default:     alu_op = OP_PASS;
    endcase
  end

  upd_alu u_alu (
    .ent_i        (alu_in),
    .op_i         (alu_op),
    .job_status_i (js_q),
    .step_i       (step_q),
    .heavy_i      (heavy_q),
    .new_prio_i   (np_q),
    .ent_o        (alu_out)
  );

  upd_mem #(
    .DEPTH (MAX_USERS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_lookup) begin
            state_d = tbl_empty ? S_MISS : S_READ;
          end else if (in_sweep) begin
            state_d = tbl_empty ? S_RESP : S_READ;
          end else if (in_mode == MODE_SLOT) begin
            state_d = slot_ok ? S_READ : S_RESP;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (q_sweep) begin
          state_d = last ? S_RESP : S_READ;
        end else if (q_lookup) begin
          if (found) state_d = S_RESP;
          else       state_d = last ? S_MISS : S_READ;
        end else begin
          state_d = S_RESP;
        end
      end
      S_MISS: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    idx_d        = idx_q;
    active_d     = active_q;
    res_we       = 1'b0;
    res_status_d = RES_OK;
    res_entry_d  = '0;
    mem_we       = 1'b0;
    mem_waddr    = idx_q;
    mem_wdata    = alu_out;
    out_load     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_we = 1'b1;
          if (in_mode == MODE_SLOT) begin
            idx_d = slot_ext[AW-1:0];
            if (!slot_ok) res_status_d = RES_NOT_FOUND;
          end else begin
            idx_d = '0;
          end
        end
      end
      S_READ: ;
      S_EVAL: begin
        if (q_sweep) begin
          mem_we = 1'b1;
          if (!last) idx_d = idx_nxt[AW-1:0];
        end else if (q_lookup) begin
          if (found) begin
            mem_we      = 1'b1;
            res_we      = 1'b1;
            res_entry_d = alu_out;
          end else if (!last) begin
            idx_d = idx_nxt[AW-1:0];
          end
        end else begin
          res_we      = 1'b1;
          res_entry_d = mem_rdata;
        end
      end
      S_MISS: begin
        res_we = 1'b1;
        if (mode_q != MODE_REPORT) begin
          res_status_d = RES_NOT_FOUND;
        end else if (tbl_full) begin
          res_status_d = RES_FULL;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = active_q[AW-1:0];
          res_entry_d = alu_out;
          active_d    = active_q + {{(CW - 1){1'b0}}, 1'b1};
        end
      end
      S_RESP: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      active_q    <= '0;
      out_valid_q <= 1'b0;
      step_q      <= 16'd1;
      heavy_q     <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_STEP:  step_q  <= cfg_data_i[15:0];
          CFG_HEAVY: heavy_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= in_mode;
      key_q  <= s_axis_tdata[15:0];
      js_q   <= s_axis_tdata[17:16];
      np_q   <= s_axis_tdata[49:18];
    end
    if (res_we) begin
      res_status_q <= res_status_d;
      res_entry_q  <= res_entry_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_entry_q  <= res_entry_q;
      out_active_q <= act_ext[5:0];
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {2'b00, out_active_q, out_entry_q.pending, out_entry_q.running,
                          out_entry_q.key, out_entry_q.prio};

endmodule
`default_nettype wire

// File: src/upd_checker.sv
// port checker for the user priority table, bound to the top level
`default_nettype none
`include "user_priority_up_down_table_defines.svh"
module upd_checker
  import upd_pkg::*;
#(
  parameter int unsigned MAX_USERS = 32
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  localparam logic [5:0] MAX_OUT = 6'(MAX_USERS);

  `UPD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")
  `UPD_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready stayed high after an accepted beat")
  `UPD_ASSERT_NOW(a_full_count, m_axis_tvalid && (m_axis_tuser == RES_FULL), m_axis_tdata[85:80] == MAX_OUT, "table full reported below capacity")
  `UPD_ASSERT_NOW(a_fail_zero, m_axis_tvalid && (m_axis_tuser != RES_OK), m_axis_tdata[79:0] == 80'd0, "failed command returned entry fields")

endmodule

bind user_priority_up_down_table upd_checker #(
  .MAX_USERS (MAX_USERS)
) u_upd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// File: verif/tb_top.sv
// self-checking testbench of the user priority up-down table
`timescale 1ns / 100ps
module tb_top;
  import upd_pkg::*;

  localparam int MAX_USERS = 32;
  localparam int DRAIN_GAP = 2 * MAX_USERS + 16;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 180;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam logic [1:0] JS_TOUCH = 2'd2;
  localparam logic [1:0] JS_TOUCH_ALT = 2'd3;
  localparam longint PRIO_HI = 64'sd2147483647;
  localparam longint PRIO_LO = -64'sd2147483648;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] key;
    logic [1:0]  js;
    logic [31:0] np;
    logic [4:0]  slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] prio;
    logic [15:0] key;
    logic [15:0] run;
    logic [15:0] pend;
    logic [5:0]  users;
  } res_t;

  typedef struct packed {
    cmd_t c;
    logic typed;
    res_t want;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;

  logic [15:0] step_q = 16'd1;
  logic [31:0] heavy_q = 32'd0;
  logic [15:0] tbl_key [MAX_USERS];
  logic [15:0] tbl_run [MAX_USERS];
  logic [15:0] tbl_pend [MAX_USERS];
  logic [31:0] tbl_prio [MAX_USERS];
  int          n_users = 0;

  res_t        answers_due [$];
  int          mismatch_count = 0;
  bit          no_idle = 1'b0;
  logic [15:0] key_pool [40];

  wire any_beat = (s_axis_tvalid & s_axis_tready) | (m_axis_tvalid & m_axis_tready) |
                  (cfg_valid_i & cfg_ready_o);

  user_priority_up_down_table #(
    .MAX_USERS(MAX_USERS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  function automatic cmd_t mk_cmd(logic [2:0] m, logic [15:0] k, logic [1:0] j,
                                  logic [31:0] p, logic [4:0] s);
    cmd_t c;
    c.mode = m;
    c.key = k;
    c.js = j;
    c.np = p;
    c.slot = s;
    return c;
  endfunction

  function automatic res_t mk_res(logic [1:0] st, logic [31:0] p, logic [15:0] k,
                                  logic [15:0] r, logic [15:0] q, logic [5:0] u);
    res_t x;
    x.status = st;
    x.prio = p;
    x.key = k;
    x.run = r;
    x.pend = q;
    x.users = u;
    return x;
  endfunction

  function automatic logic [31:0] ticked(logic [15:0] run, logic [15:0] pend,
                                         logic [31:0] pr);
    longint p, r, st, hv;
    p = longint'($signed(pr));
    st = longint'(step_q);
    hv = longint'($signed(heavy_q));
    if (run != 16'd0) begin
      r = p + longint'(run) * st;
    end else if (pend != 16'd0) begin
      r = p - st;
    end else if (p > 0) begin
      r = (p > hv) ? hv : p - st;
      if (r < 0) r = 0;
    end else if (p < 0) begin
      r = p + st;
      if (r > 0) r = 0;
    end else begin
      r = 0;
    end
    if (r > PRIO_HI) r = PRIO_HI;
    else if (r < PRIO_LO) r = PRIO_LO;
    return r[31:0];
  endfunction

  function automatic res_t share_table_step(cmd_t c);
    res_t r;
    int   idx;
    r = '0;
    idx = -1;
    for (int i = 0; i < n_users; i++) begin
      if (idx < 0 && tbl_key[i] == c.key) idx = i;
    end
    case (c.mode)
      MODE_CLEAR: begin
        for (int i = 0; i < n_users; i++) begin
          tbl_run[i] = '0;
          tbl_pend[i] = '0;
        end
      end
      MODE_REPORT: begin
        if (idx < 0 && n_users >= MAX_USERS) begin
          r.status = RES_FULL;
        end else begin
          if (idx < 0) begin
            idx = n_users;
            tbl_key[idx] = c.key;
            tbl_run[idx] = '0;
            tbl_pend[idx] = '0;
            tbl_prio[idx] = '0;
            n_users++;
          end
          if (c.js == JS_RUNNING && tbl_run[idx] != CNT_MAX) tbl_run[idx]++;
          else if (c.js == JS_PENDING && tbl_pend[idx] != CNT_MAX) tbl_pend[idx]++;
        end
      end
      MODE_GETP, MODE_SETP: begin
        if (idx < 0) r.status = RES_NOT_FOUND;
        else if (c.mode == MODE_SETP) tbl_prio[idx] = c.np;
      end
      MODE_TICK: begin
        for (int i = 0; i < n_users; i++) tbl_prio[i] = ticked(tbl_run[i], tbl_pend[i], tbl_prio[i]);
        idx = -1;
      end
      MODE_SLOT: begin
        if (int'(c.slot) < n_users) idx = int'(c.slot);
        else r.status = RES_NOT_FOUND;
      end
      default: idx = -1;
    endcase
    if (c.mode == MODE_CLEAR || r.status != RES_OK) idx = -1;
    if (idx >= 0) begin
      r.prio = tbl_prio[idx];
      r.key = tbl_key[idx];
      r.run = tbl_run[idx];
      r.pend = tbl_pend[idx];
    end
    r.users = n_users[5:0];
    return r;
  endfunction

  function automatic cmd_t random_cmd(int pool_n);
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 38) c.mode = MODE_REPORT;
    else if (pick < 50) c.mode = MODE_GETP;
    else if (pick < 60) c.mode = MODE_SETP;
    else if (pick < 74) c.mode = MODE_TICK;
    else if (pick < 88) c.mode = MODE_SLOT;
    else if (pick < 94) c.mode = MODE_CLEAR;
    else c.mode = pick[0] ? MODE_SPARE7 : MODE_SPARE6;
    c.key = ($urandom_range(0, 99) < 94) ? key_pool[$urandom_range(0, pool_n - 1)] :
            16'($urandom_range(0, 65535));
    c.js = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 99);
    if (pick < 30) c.np = $urandom();
    else if (pick < 38) c.np = 32'h7FFFFFFF - 32'($urandom_range(0, 3));
    else if (pick < 46) c.np = 32'h80000000 + 32'($urandom_range(0, 3));
    else c.np = 32'($signed($urandom_range(0, 400)) - 200);
    if (n_users > 0 && $urandom_range(0, 3) != 0) c.slot = 5'($urandom_range(0, n_users - 1));
    else c.slot = 5'($urandom_range(0, 31));
    return c;
  endfunction

  task automatic issue(cmd_t c, logic typed, res_t want);
    res_t p;
    while (!no_idle && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= c.mode;
    s_axis_tdata <= {1'b0, c.slot, c.np, c.js, c.key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    p = share_table_step(c);
    answers_due.push_back(typed ? want : p);
  endtask

  task automatic write_regs(logic [31:0] step_val, logic [31:0] heavy_val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_STEP;
    cfg_data_i <= step_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    step_q = step_val[15:0];
    cfg_index_i <= CFG_HEAVY;
    cfg_data_i <= heavy_val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    heavy_q = heavy_val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_GAP) @(posedge clk_i);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tuser;
        got.prio = m_axis_tdata[31:0];
        got.key = m_axis_tdata[47:32];
        got.run = m_axis_tdata[63:48];
        got.pend = m_axis_tdata[79:64];
        got.users = m_axis_tdata[85:80];
        if (answers_due.size() == 0) begin
          mismatch_count++;
          $error("result beat with nothing outstanding");
        end else begin
          want = answers_due.pop_front();
          check_field("result_status", want.status, got.status);
          check_field("priority_out", longint'($signed(want.prio)),
                      longint'($signed(got.prio)));
          check_field("key_out", want.key, got.key);
          check_field("running_out", want.run, got.run);
          check_field("pending_out", want.pend, got.pend);
          check_field("active_users_out", want.users, got.users);
        end
      end
      m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 8);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      quiet = any_beat ? 0 : quiet + 1;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    row_t        plan [$];
    logic [31:0] step_plan [PHASES];
    logic [31:0] heavy_plan [PHASES];
    int          pool_plan [PHASES];
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_STEP;
    cfg_data_i = '0;
    foreach (key_pool[i]) key_pool[i] = 16'($urandom_range(0, 65535));
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    step_plan = '{32'd1, 32'd0, 32'h0000FFFF, 32'hFFFFFFFF, $urandom(), 32'hFFFF0003,
                  32'($urandom_range(0, 64)), $urandom()};
    heavy_plan = '{32'd0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, $urandom(), 32'd100,
                   32'hFFFFFF00, 32'($urandom_range(0, 5000))};
    pool_plan = '{6, 12, 20, 28, 34, 40, 40, 40};

    plan.push_back(row_t'{mk_cmd(MODE_GETP, 16'h1234, JS_RUNNING, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_NOT_FOUND, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0)});
    plan.push_back(row_t'{mk_cmd(MODE_SLOT, 16'h0, JS_RUNNING, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_NOT_FOUND, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0)});
    plan.push_back(row_t'{mk_cmd(MODE_TICK, 16'h0, JS_RUNNING, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_OK, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0)});
    plan.push_back(row_t'{mk_cmd(MODE_CLEAR, 16'h0, JS_RUNNING, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_OK, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0)});
    plan.push_back(row_t'{mk_cmd(MODE_SPARE6, 16'hAAAA, JS_TOUCH, 32'h55555555, 5'd10), 1'b1,
                          mk_res(RES_OK, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0)});
    plan.push_back(row_t'{mk_cmd(MODE_SPARE7, 16'hFFFF, JS_TOUCH_ALT, 32'hFFFFFFFF, 5'd31),
                          1'b1, mk_res(RES_OK, 32'h0, 16'h0, 16'h0, 16'h0, 6'd0)});
    plan.push_back(row_t'{mk_cmd(MODE_REPORT, 16'hFFFF, JS_RUNNING, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_OK, 32'h0, 16'hFFFF, 16'd1, 16'd0, 6'd1)});
    plan.push_back(row_t'{mk_cmd(MODE_REPORT, 16'h0000, JS_PENDING, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_OK, 32'h0, 16'h0000, 16'd0, 16'd1, 6'd2)});
    plan.push_back(row_t'{mk_cmd(MODE_REPORT, 16'h5A5A, JS_TOUCH, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_OK, 32'h0, 16'h5A5A, 16'd0, 16'd0, 6'd3)});
    plan.push_back(row_t'{mk_cmd(MODE_REPORT, 16'hA5A5, JS_TOUCH_ALT, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_OK, 32'h0, 16'hA5A5, 16'd0, 16'd0, 6'd4)});
    plan.push_back(row_t'{mk_cmd(MODE_SETP, 16'h5A5A, JS_RUNNING, 32'h7FFFFFFF, 5'd0), 1'b1,
                          mk_res(RES_OK, 32'h7FFFFFFF, 16'h5A5A, 16'd0, 16'd0, 6'd4)});
    plan.push_back(row_t'{mk_cmd(MODE_SETP, 16'hA5A5, JS_RUNNING, 32'h80000000, 5'd0), 1'b1,
                          mk_res(RES_OK, 32'h80000000, 16'hA5A5, 16'd0, 16'd0, 6'd4)});
    plan.push_back(row_t'{mk_cmd(MODE_SETP, 16'h0000, JS_RUNNING, 32'h80000003, 5'd0), 1'b0,
                          '0});
    plan.push_back(row_t'{mk_cmd(MODE_TICK, 16'h0, JS_RUNNING, 32'h0, 5'd0), 1'b0, '0});
    plan.push_back(row_t'{mk_cmd(MODE_GETP, 16'h0000, JS_RUNNING, 32'h0, 5'd0), 1'b0, '0});
    plan.push_back(row_t'{mk_cmd(MODE_SLOT, 16'h0, JS_RUNNING, 32'h0, 5'd3), 1'b0, '0});
    plan.push_back(row_t'{mk_cmd(MODE_SLOT, 16'h0, JS_RUNNING, 32'h0, 5'd31), 1'b1,
                          mk_res(RES_NOT_FOUND, 32'h0, 16'h0, 16'h0, 16'h0, 6'd4)});
    plan.push_back(row_t'{mk_cmd(MODE_SETP, 16'hFFFF, JS_RUNNING, 32'h7FFFFFFE, 5'd0), 1'b0,
                          '0});
    plan.push_back(row_t'{mk_cmd(MODE_REPORT, 16'hFFFF, JS_RUNNING, 32'h0, 5'd0), 1'b0, '0});
    plan.push_back(row_t'{mk_cmd(MODE_TICK, 16'h0, JS_RUNNING, 32'h0, 5'd0), 1'b0, '0});
    plan.push_back(row_t'{mk_cmd(MODE_SLOT, 16'h0, JS_RUNNING, 32'h0, 5'd0), 1'b0, '0});
    plan.push_back(row_t'{mk_cmd(MODE_GETP, 16'h1111, JS_RUNNING, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_NOT_FOUND, 32'h0, 16'h0, 16'h0, 16'h0, 6'd4)});
    plan.push_back(row_t'{mk_cmd(MODE_CLEAR, 16'h0, JS_RUNNING, 32'h0, 5'd0), 1'b1,
                          mk_res(RES_OK, 32'h0, 16'h0, 16'h0, 16'h0, 6'd4)});
    plan.push_back(row_t'{mk_cmd(MODE_SLOT, 16'h0, JS_RUNNING, 32'h0, 5'd1), 1'b0, '0});
    plan.push_back(row_t'{mk_cmd(MODE_SETP, 16'h3C3C, JS_RUNNING, 32'h3FFFFFFF, 5'd0), 1'b1,
                          mk_res(RES_NOT_FOUND, 32'h0, 16'h0, 16'h0, 16'h0, 6'd4)});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) issue(plan[i].c, plan[i].typed, plan[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_regs(step_plan[ph], heavy_plan[ph]);
      no_idle = (ph == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) issue(random_cmd(pool_plan[ph]), 1'b0, '0);
    end
    no_idle = 1'b0;

    settle();
    if (mismatch_count == 0 && answers_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/upd_pkg.sv
src/upd_mem.sv
src/upd_alu.sv
src/user_priority_up_down_table.sv
src/upd_checker.sv
verif/tb_top.sv
